// ===== hw/rtl/serial_set_square_wave_generator_macros.svh =====
// Assertion macros shared by the serial set square wave generator.
`ifndef SERIAL_SET_SQUARE_WAVE_GENERATOR_MACROS_SVH
`define SERIAL_SET_SQUARE_WAVE_GENERATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SSWG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SSWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sswg_pkg.sv =====
`default_nettype none
package sswg_pkg;

	localparam logic [23:0] CLOCK_HZ  = 24'd16000000;
	localparam int          DIV_STEPS = 24;
	localparam int          DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic signed [31:0] FREQ_MIN = 32'sd2;
	localparam logic signed [31:0] FREQ_MAX = 32'sd7999999;

	// Prescaler codes
	localparam logic [2:0] PS_DIV1    = 3'd0;
	localparam logic [2:0] PS_DIV8    = 3'd1;
	localparam logic [2:0] PS_DIV64   = 3'd2;
	localparam logic [2:0] PS_DIV256  = 3'd3;
	localparam logic [2:0] PS_DIV1024 = 3'd4;

	localparam logic [31:0] FREQ_RST = 32'd2;
	localparam logic [15:0] CMP_RST  = 16'd3905;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_out;
		logic start_div;
		logic step_div;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_stat_t;

	// Prescaler division ratio, as a count limit
	function automatic logic [10:0] prescale_limit(input logic [2:0] code);
		logic [10:0] lim;
		unique case (code)
			PS_DIV1:   lim = 11'd1;
			PS_DIV8:   lim = 11'd8;
			PS_DIV64:  lim = 11'd64;
			PS_DIV256: lim = 11'd256;
			default:   lim = 11'd1024;
		endcase
		return lim;
	endfunction

	// log2 of (2 * prescaler ratio)
	function automatic logic [3:0] denom_shift(input logic [2:0] code);
		logic [3:0] sh;
		unique case (code)
			PS_DIV1:   sh = 4'd1;
			PS_DIV8:   sh = 4'd4;
			PS_DIV64:  sh = 4'd7;
			PS_DIV256: sh = 4'd9;
			default:   sh = 4'd11;
		endcase
		return sh;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sswg_ctrl.sv =====
`default_nettype none
`include "serial_set_square_wave_generator_macros.svh"
module sswg_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	input  sswg_pkg::dp_stat_t   stat,
	output sswg_pkg::ctl_cmd_t   cmd
);

	sswg_pkg::state_t state_q, state_nx;
	logic out_valid_q;
	logic can_load;

	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sswg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		state_nx = state_q;
		unique case (state_q)
			sswg_pkg::ST_IDLE: begin
				in_stall = !can_load;
				if (in_valid && can_load) begin
					cmd.accept = 1'b1;
					if (stat.need_div) begin
						cmd.start_div = 1'b1;
						state_nx      = sswg_pkg::ST_DIV;
					end else begin
						cmd.load_out = 1'b1;
					end
				end
			end
			sswg_pkg::ST_DIV: begin
				cmd.step_div = 1'b1;
				if (stat.div_last) begin
					state_nx = sswg_pkg::ST_DONE;
				end
			end
			sswg_pkg::ST_DONE: begin
				if (can_load) begin
					cmd.commit   = 1'b1;
					cmd.load_out = 1'b1;
					state_nx     = sswg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = sswg_pkg::ST_IDLE;
			end
		endcase
	end

	`SSWG_ASSERT_NEXT(a_start_enters_div, clk, arst_n, cmd.start_div, state_q == sswg_pkg::ST_DIV, "divide did not start")
	`SSWG_ASSERT_NEXT(a_last_step_done, clk, arst_n, (state_q == sswg_pkg::ST_DIV) && stat.div_last, state_q == sswg_pkg::ST_DONE, "divide did not finish")
	`SSWG_ASSERT_SAME(a_no_accept_busy, clk, arst_n, state_q != sswg_pkg::ST_IDLE, !cmd.accept, "beat taken while busy")
	`SSWG_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, out_valid, "commit without result")

endmodule
`default_nettype wire

// ===== hw/rtl/sswg_dp.sv =====
`default_nettype none
module sswg_dp (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sswg_pkg::ctl_cmd_t    cmd,
	output sswg_pkg::dp_stat_t    stat,
	input  wire                   op,
	input  wire  [7:0]            rx_byte,
	output logic                  wave_out,
	output logic                  word_done,
	output logic                  word_rejected,
	output logic [15:0]           compare_value,
	output logic [2:0]            prescale_sel,
	output logic signed [31:0]    freq_setting
);

	// architectural state
	logic [1:0]  byte_idx_q, byte_idx_nx;
	logic [23:0] partial_q, partial_nx;
	logic [31:0] freq_q, freq_nx;
	logic [2:0]  code_q, code_nx;
	logic [15:0] cmp_q, cmp_nx;
	logic [9:0]  pcount_q, pcount_nx;
	logic [15:0] tcount_q, tcount_nx;
	logic        wave_q, wave_nx;

	// divider and pending setting
	logic [23:0] rem_q, quo_q, den_q;
	logic [sswg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [31:0] pend_freq_q;
	logic [2:0]  pend_code_q;

	logic [31:0]        word;
	logic signed [31:0] word_s;
	logic               complete, reject;
	logic [2:0]         new_code;
	logic [23:0]        new_den;
	logic [24:0]        trial;
	logic               ge;
	logic               done_nx, rej_nx;

	assign word     = {rx_byte, partial_q};
	assign word_s   = $signed(word);
	assign complete = !op && (byte_idx_q == 2'd3);
	assign reject   = (word_s < sswg_pkg::FREQ_MIN) || (word_s > sswg_pkg::FREQ_MAX);

	assign stat.need_div = complete && !reject;
	assign stat.div_last = (cnt_q == sswg_pkg::DIV_CNT_W'(sswg_pkg::DIV_STEPS - 1));

	always_comb begin
		if (word[22:0] > 23'd122) begin
			new_code = sswg_pkg::PS_DIV1;
		end else if (word[22:0] > 23'd15) begin
			new_code = sswg_pkg::PS_DIV8;
		end else if (word[22:0] > 23'd2) begin
			new_code = sswg_pkg::PS_DIV64;
		end else begin
			new_code = sswg_pkg::PS_DIV256;
		end
		new_den = {1'b0, word[22:0]} << sswg_pkg::denom_shift(new_code);
	end

	// one restoring step: shift in the next dividend bit
	assign trial = {rem_q, quo_q[23]};
	assign ge    = trial >= {1'b0, den_q};

	always_comb begin
		byte_idx_nx = byte_idx_q;
		partial_nx  = partial_q;
		freq_nx     = freq_q;
		code_nx     = code_q;
		cmp_nx      = cmp_q;
		pcount_nx   = pcount_q;
		tcount_nx   = tcount_q;
		wave_nx     = wave_q;
		done_nx     = 1'b0;
		rej_nx      = 1'b0;
		if (cmd.commit) begin
			freq_nx   = pend_freq_q;
			code_nx   = pend_code_q;
			cmp_nx    = quo_q[15:0] - 16'd1;
			pcount_nx = '0;
			tcount_nx = '0;
			done_nx   = 1'b1;
		end else if (op) begin
			if ({1'b0, pcount_q} + 11'd1 >= sswg_pkg::prescale_limit(code_q)) begin
				pcount_nx = '0;
				if (tcount_q == cmp_q) begin
					tcount_nx = '0;
					wave_nx   = !wave_q;
				end else begin
					tcount_nx = tcount_q + 16'd1;
				end
			end else begin
				pcount_nx = pcount_q + 10'd1;
			end
		end else if (complete) begin
			byte_idx_nx = '0;
			partial_nx  = '0;
			done_nx     = 1'b1;
			rej_nx      = reject;
		end else begin
			partial_nx  = partial_q | (24'(rx_byte) << {byte_idx_q, 3'b000});
			byte_idx_nx = byte_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			partial_q  <= '0;
			freq_q     <= sswg_pkg::FREQ_RST;
			code_q     <= sswg_pkg::PS_DIV1024;
			cmp_q      <= sswg_pkg::CMP_RST;
			pcount_q   <= '0;
			tcount_q   <= '0;
			wave_q     <= 1'b0;
		end else if (cmd.accept || cmd.commit) begin
			byte_idx_q <= byte_idx_nx;
			partial_q  <= partial_nx;
			freq_q     <= freq_nx;
			code_q     <= code_nx;
			cmp_q      <= cmp_nx;
			pcount_q   <= pcount_nx;
			tcount_q   <= tcount_nx;
			wave_q     <= wave_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q       <= '0;
			quo_q       <= sswg_pkg::CLOCK_HZ;
			den_q       <= new_den;
			cnt_q       <= '0;
			pend_freq_q <= word;
			pend_code_q <= new_code;
		end else if (cmd.step_div) begin
			rem_q <= ge ? 24'(trial - {1'b0, den_q}) : trial[23:0];
			quo_q <= {quo_q[22:0], ge};
			cnt_q <= cnt_q + sswg_pkg::DIV_CNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			wave_out      <= wave_nx;
			word_done     <= done_nx;
			word_rejected <= rej_nx;
			compare_value <= cmp_nx;
			prescale_sel  <= code_nx;
			freq_setting  <= $signed(freq_nx);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/serial_set_square_wave_generator.sv =====
`default_nettype none
// Square-wave generator whose frequency is set over a serial link. Each input
// beat is either a received byte (op = 0) or one clock tick (op = 1), and each
// beat yields exactly one result beat carrying the wave level and the settings
// in use. Bytes gather little-endian into a signed 32-bit frequency word; on
// the fourth byte a word in 2..7999999 picks the prescaler (1, 8, 64 or 256),
// loads compare = 16000000 / (freq * 2 * prescaler) - 1 and clears the
// counters, while a word outside that range raises word_rejected and keeps
// all settings. Ticks, the first three bytes of a word and rejected words load
// the result register as they are taken, so the block takes one beat per cycle
// while results drain. An accepted word is taken, then runs 24 steps of the
// bit-serial restoring divider (one quotient bit per cycle), then commits the
// new setting and loads the result register; input is stalled meanwhile.
// After reset the wave runs at 2 Hz with the divide-by-1024 prescaler.
module serial_set_square_wave_generator (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                op,
	input  wire  [7:0]         rx_byte,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               wave_out,
	output logic               word_done,
	output logic               word_rejected,
	output logic [15:0]        compare_value,
	output logic [2:0]         prescale_sel,
	output logic signed [31:0] freq_setting
);

	// command and status between sequencer and datapath
	sswg_pkg::ctl_cmd_t cmd;
	sswg_pkg::dp_stat_t stat;

	// sequencer: handshakes, divide sequencing, result register valid
	sswg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: byte assembly, range check, divider, prescaler and timer
	sswg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.op            (op),
		.rx_byte       (rx_byte),
		.wave_out      (wave_out),
		.word_done     (word_done),
		.word_rejected (word_rejected),
		.compare_value (compare_value),
		.prescale_sel  (prescale_sel),
		.freq_setting  (freq_setting)
	);

endmodule
`default_nettype wire
